[hdl/rsamx_pkg.sv]
// shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps

package rsamx_pkg;

   // width of the configuration register index
   localparam int CSR_INDEX_WIDTH = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 8'd1;

   // exponentiation sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL_ACC,
      ST_MUL_SQR,
      ST_FINISH
   } state_type;

endpackage

[hdl/rsamx_mulmod.sv]
// bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle
`timescale 1ns / 1ps

module rsamx_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   input  logic [WIDTH-1:0]     m,
   output logic                 done,
   output logic [WIDTH-1:0]     product
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     a_ff, a_in;
   logic [WIDTH-1:0]     b_sh_ff, b_sh_in;

   logic [WIDTH+1:0]     sum;
   logic [WIDTH+1:0]     m1;
   logic [WIDTH+1:0]     m2;
   logic [WIDTH+1:0]     addend;

   // one step: acc = (2*acc + bit*a) mod m, sum stays below 3m
   always_comb begin
      m1     = {2'b00, m};
      m2     = {1'b0, m, 1'b0};
      addend = b_sh_ff[WIDTH-1] ? {2'b00, a_ff} : '0;
      sum    = {1'b0, acc_ff, 1'b0} + addend;

      cnt_in  = cnt_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_sh_in = b_sh_ff;

      if (start) begin
         cnt_in  = CNT_WIDTH'(WIDTH);
         acc_in  = '0;
         a_in    = a;
         b_sh_in = b;
      end else if (cnt_ff != '0) begin
         if (sum >= m2) begin
            acc_in = WIDTH'(sum - m2);
         end else if (sum >= m1) begin
            acc_in = WIDTH'(sum - m1);
         end else begin
            acc_in = sum[WIDTH-1:0];
         end
         b_sh_in = {b_sh_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_WIDTH'(1));
      end
   end

   // step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // operand and accumulator registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_sh_ff <= b_sh_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[hdl/rsa_modular_exponentiation.sv]
// modular exponentiation top level: sequencer, configuration registers, result register
`timescale 1ns / 1ps

// Computes result = message^exponent mod modulus by right-to-left square-and-multiply.
// Exponent (index 0, reset 3) and modulus (index 1, reset 1) are written through the
// csr port; the user must write them only while no message is in flight, the block
// itself does not enforce this. One shared bit-serial modular multiplier does all
// arithmetic, including the initial reduction of the message (message * 1 mod n).
// For each exponent bit, lowest first, the accumulator is multiplied by the base when
// the bit is set, and then the base is squared; all WIDTH bits are processed.
// A zero modulus returns 0 without any multiply, a message that reduces to zero
// returns 0 right after the reduction.
// One message is processed at a time; a finished result waits in the output register
// while the next message is already accepted.

module rsa_modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [WIDTH-1:0]                     req_message,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [WIDTH-1:0]                     rsp_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rsamx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]                     csr_data
);

   import rsamx_pkg::*;

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   state_type            state_ff, state_in;
   logic [WIDTH-1:0]     exponent_ff, exponent_in;
   logic [WIDTH-1:0]     modulus_ff, modulus_in;
   logic [CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     base_ff, base_in;
   logic [WIDTH-1:0]     e_sh_ff, e_sh_in;
   logic [WIDTH-1:0]     res_ff, res_in;
   logic [WIDTH-1:0]     rsp_result_ff, rsp_result_in;

   logic                 mm_start;
   logic                 mm_done;
   logic [WIDTH-1:0]     mm_a;
   logic [WIDTH-1:0]     mm_b;
   logic [WIDTH-1:0]     mm_product;
   logic [WIDTH-1:0]     one_mod;
   logic                 req_beat;
   logic                 rsp_beat;
   logic                 rsp_free;

   // shared modular multiplier
   rsamx_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a       (mm_a),
      .b       (mm_b),
      .m       (modulus_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // 1 mod n: zero only when n is one
   assign one_mod = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);

   // configuration register writes
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXPONENT: exponent_in = csr_data;
            CSR_MODULUS:  modulus_in  = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer next state and datapath control
   always_comb begin
      state_in      = state_ff;
      bit_cnt_in    = bit_cnt_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      e_sh_in       = e_sh_ff;
      res_in        = res_ff;
      mm_start      = 1'b0;
      mm_a          = acc_ff;
      mm_b          = base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_beat;
      rsp_result_in = rsp_result_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               acc_in     = one_mod;
               e_sh_in    = exponent_ff;
               bit_cnt_in = CNT_WIDTH'(WIDTH);
               if (modulus_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  // reduce the message as message * 1 mod n
                  mm_start = 1'b1;
                  mm_a     = one_mod;
                  mm_b     = req_message;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               base_in = mm_product;
               if (mm_product == '0) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (bit_cnt_ff == '0) begin
               res_in   = acc_ff;
               state_in = ST_FINISH;
            end else if (e_sh_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               mm_b     = base_ff;
               state_in = ST_MUL_ACC;
            end else begin
               mm_start = 1'b1;
               mm_a     = base_ff;
               mm_b     = base_ff;
               state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_ACC: begin
            if (mm_done) begin
               acc_in   = mm_product;
               mm_start = 1'b1;
               mm_a     = base_ff;
               mm_b     = base_ff;
               state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_SQR: begin
            if (mm_done) begin
               base_in    = mm_product;
               e_sh_in    = {1'b0, e_sh_ff[WIDTH-1:1]};
               bit_cnt_in = bit_cnt_ff - 1'b1;
               state_in   = ST_STEP;
            end
         end
         ST_FINISH: begin
            // move the result into the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exponent_ff  <= WIDTH'(3);
         modulus_ff   <= WIDTH'(1);
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      e_sh_ff       <= e_sh_in;
      res_ff        <= res_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
